// ----- rtl/cdoe_pkg.sv -----
// ----------------------------------------------------------------------------
// cdoe_pkg
// types, constants and calendar arithmetic for the date offset engine
// ----------------------------------------------------------------------------
package cdoe_pkg;

  localparam logic [11:0] BASE_YEAR = 12'd1900;
  localparam logic [12:0] BASE_YEAR_M1 = 13'd1899;
  // leap count term of the year before the base year
  localparam logic [21:0] BASE_LEAP_TERM = 22'd460;
  localparam logic [25:0] RECIP_100 = 26'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned IN_W = 48;
  localparam int unsigned OUT_W = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_CHECK,
    ST_SEARCH,
    ST_REM,
    ST_MONTH,
    ST_DONE
  } cdoe_state_t;

  // quotient by 100 through a reciprocal, exact for x below 8192
  function automatic logic [6:0] div100(input logic [12:0] x);
    logic [25:0] p;
    begin
      p = 26'(x) * RECIP_100;
      return p[RECIP_SHIFT +: 7];
    end
  endfunction

  function automatic logic is_leap(input logic [11:0] y);
    logic [6:0] q;
    logic [13:0] back;
    logic cent;
    begin
      q = div100({1'b0, y});
      back = 14'(q) * 14'd100;
      cent = (back[11:0] == y);
      return (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
    end
  endfunction

  function automatic logic [4:0] days_in_mon(input logic leap, input logic [3:0] m);
    logic [4:0] n;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
        4'd2: n = leap ? 5'd29 : 5'd28;
        default: n = 5'd0;
      endcase
      return n;
    end
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] n;
    begin
      case (m)
        4'd1: n = 9'd0;
        4'd2: n = 9'd31;
        4'd3: n = 9'd59;
        4'd4: n = 9'd90;
        4'd5: n = 9'd120;
        4'd6: n = 9'd151;
        4'd7: n = 9'd181;
        4'd8: n = 9'd212;
        4'd9: n = 9'd243;
        4'd10: n = 9'd273;
        4'd11: n = 9'd304;
        4'd12: n = 9'd334;
        default: n = 9'd0;
      endcase
      return n;
    end
  endfunction

  // days in the years from the base year up to, not including, base + n
  function automatic logic [20:0] yr_base_days(input logic [11:0] n);
    logic [12:0] x;
    logic [12:0] x4;
    logic [6:0] q100;
    logic [6:0] q400;
    logic [21:0] d;
    begin
      x = 13'(n) + BASE_YEAR_M1;
      x4 = x >> 2;
      q100 = div100(x);
      q400 = div100(x4);
      d = 22'(n) * 22'd365 + 22'(x4) + 22'(q400) - 22'(q100) - BASE_LEAP_TERM;
      return d[20:0];
    end
  endfunction

  // remainder by 7 by folding octal digits
  function automatic logic [2:0] mod7(input logic [19:0] s);
    logic [20:0] v;
    logic [5:0] s1;
    logic [3:0] t;
    begin
      v = {1'b0, s};
      s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) +
           6'(v[17:15]) + 6'(v[20:18]);
      t = 4'(s1[2:0]) + 4'(s1[5:3]);
      if (t >= 4'd7) begin
        t = t - 4'd7;
      end
      return t[2:0];
    end
  endfunction

endpackage

// ----- rtl/cdoe_year_base.sv -----
// ----------------------------------------------------------------------------
// cdoe_year_base
// shared year unit: day count before a year index and compare to a limit
// ----------------------------------------------------------------------------
module cdoe_year_base
  import cdoe_pkg::*;
(
  input  logic [11:0] idx,
  input  logic [20:0] limit,
  output logic [20:0] days,
  output logic        below
);

  assign days  = yr_base_days(idx);
  assign below = (days < limit);

endmodule

// ----- rtl/calendar_date_offset_engine_core.sv -----
// ----------------------------------------------------------------------------
// calendar_date_offset_engine_core
// gregorian date check, serial day, weekday and offset date
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block takes a beat only when idle and
// holds the result until it is taken. An invalid date goes from acceptance
// through ST_BASE to ST_DONE; a date whose offset falls out of range goes on
// through ST_CHECK to ST_DONE; otherwise a 12-step binary search over the
// year index through the shared year unit, ST_REM, and a walk of up to 11
// months by one subtract/compare each come before ST_DONE.
module calendar_date_offset_engine_core
  import cdoe_pkg::*;
#(
  parameter int YEAR_SPAN = 2048
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // in_day[4:0], in_month[8:5], in_year[20:9], day_offset[41:21], zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // input_ok[0], serial_day[20:1], day_of_year[29:21], weekday[32:30],
  // result_day[37:33], result_month[41:38], result_year[53:42],
  // result_ok[54], zero pad
  output logic [OUT_W-1:0] out_tdata
);

  localparam logic [12:0] SPAN13 = 13'(YEAR_SPAN);
  localparam logic [20:0] TOTAL  = yr_base_days(12'(YEAR_SPAN));

  cdoe_state_t state_r, state_nxt;

  logic [4:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [11:0] year_r, year_nxt;
  logic [20:0] off_r, off_nxt;
  logic [19:0] serial_r, serial_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic        iok_r, iok_nxt;
  logic [21:0] tgt_r, tgt_nxt;
  logic [11:0] idx_r, idx_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [3:0]  rm_r, rm_nxt;
  logic [4:0]  rday_r, rday_nxt;
  logic [3:0]  rmon_r, rmon_nxt;
  logic [11:0] ryear_r, ryear_nxt;
  logic        rok_r, rok_nxt;

  logic [11:0] unit_idx;
  logic [20:0] unit_days;
  logic        unit_below;

  logic [11:0] yidx;
  logic        in_leap;
  logic        date_ok;
  logic [8:0]  doy_c;
  logic [11:0] cand;
  logic [21:0] tgt_c;
  logic [20:0] rem_c;
  logic [11:0] ry_c;
  logic [4:0]  dim_c;

  cdoe_year_base u_year (
    .idx   (unit_idx),
    .limit (tgt_r[20:0]),
    .days  (unit_days),
    .below (unit_below)
  );

  assign yidx    = year_r - BASE_YEAR;
  assign in_leap = is_leap(year_r);
  assign date_ok = (year_r >= BASE_YEAR) && ({1'b0, yidx} < SPAN13) &&
                   (mon_r >= 4'd1) && (mon_r <= 4'd12) && (day_r >= 5'd1) &&
                   (day_r <= days_in_mon(in_leap, mon_r));
  assign doy_c   = 9'(day_r) + cum_days(mon_r) + 9'(in_leap && (mon_r > 4'd2));
  assign cand    = idx_r | (12'd1 << bit_r);
  assign tgt_c   = $signed({2'b00, serial_r}) + $signed({off_r[20], off_r});
  assign rem_c   = tgt_r[20:0] - unit_days;
  assign ry_c    = BASE_YEAR + idx_r;
  assign dim_c   = days_in_mon(is_leap(ry_c), rm_r);

  always_comb begin
    unit_idx = yidx;
    case (state_r)
      ST_SEARCH: unit_idx = cand;
      ST_REM:    unit_idx = idx_r;
      default:   unit_idx = yidx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r    <= day_nxt;
    mon_r    <= mon_nxt;
    year_r   <= year_nxt;
    off_r    <= off_nxt;
    serial_r <= serial_nxt;
    doy_r    <= doy_nxt;
    wd_r     <= wd_nxt;
    iok_r    <= iok_nxt;
    tgt_r    <= tgt_nxt;
    idx_r    <= idx_nxt;
    bit_r    <= bit_nxt;
    rem_r    <= rem_nxt;
    rm_r     <= rm_nxt;
    rday_r   <= rday_nxt;
    rmon_r   <= rmon_nxt;
    ryear_r  <= ryear_nxt;
    rok_r    <= rok_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    day_nxt    = day_r;
    mon_nxt    = mon_r;
    year_nxt   = year_r;
    off_nxt    = off_r;
    serial_nxt = serial_r;
    doy_nxt    = doy_r;
    wd_nxt     = wd_r;
    iok_nxt    = iok_r;
    tgt_nxt    = tgt_r;
    idx_nxt    = idx_r;
    bit_nxt    = bit_r;
    rem_nxt    = rem_r;
    rm_nxt     = rm_r;
    rday_nxt   = rday_r;
    rmon_nxt   = rmon_r;
    ryear_nxt  = ryear_r;
    rok_nxt    = rok_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          day_nxt   = in_tdata[4:0];
          mon_nxt   = in_tdata[8:5];
          year_nxt  = in_tdata[20:9];
          off_nxt   = in_tdata[41:21];
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        rday_nxt  = 5'd0;
        rmon_nxt  = 4'd0;
        ryear_nxt = 12'd0;
        rok_nxt   = 1'b0;
        if (date_ok) begin
          iok_nxt    = 1'b1;
          doy_nxt    = doy_c;
          serial_nxt = 20'(unit_days) + 20'(doy_c);
          state_nxt  = ST_CHECK;
        end else begin
          iok_nxt    = 1'b0;
          doy_nxt    = 9'd0;
          serial_nxt = 20'd0;
          wd_nxt     = 3'd0;
          state_nxt  = ST_DONE;
        end
      end
      ST_CHECK: begin
        wd_nxt  = mod7(serial_r);
        tgt_nxt = tgt_c;
        idx_nxt = 12'd0;
        bit_nxt = 4'd11;
        if ($signed(tgt_c) < $signed(22'sd1) ||
            $signed(tgt_c) > $signed({1'b0, TOTAL})) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (({1'b0, cand} < SPAN13) && unit_below) begin
          idx_nxt = cand;
        end
        bit_nxt = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        rem_nxt   = rem_c[8:0];
        rm_nxt    = 4'd1;
        state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        if ((rm_r < 4'd12) && (rem_r > 9'(dim_c))) begin
          rem_nxt = rem_r - 9'(dim_c);
          rm_nxt  = rm_r + 4'd1;
        end else begin
          rday_nxt  = rem_r[4:0];
          rmon_nxt  = rm_r;
          ryear_nxt = ry_c;
          rok_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tdata = {1'b0, rok_r, ryear_r, rmon_r, rday_r, wd_r, doy_r, serial_r, iok_r};

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input and output sides open together");

  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rok_r) |-> (iok_r && (rmon_r >= 4'd1) && (rmon_r <= 4'd12) &&
                               (rday_r >= 5'd1)))
    else $error("offset date flagged good without a valid date");

  a_search_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && bit_r == 4'd0) |=> (state_r == ST_REM))
    else $error("year search did not end after its last bit");

endmodule
